### design/pwsh_pkg.sv
// ----------------------------------------------------------------------------
// pwsh_pkg
// Shared types and constants of the wheel speed controller with H-bridge drive
// ----------------------------------------------------------------------------
`default_nettype none

package pwsh_pkg;

   localparam int SPEED_FRAC_BITS = 12;
   localparam int DUTY_MAX        = 65535;
   localparam int MUL_W           = 21;
   localparam int PROD_W          = 2 * MUL_W;
   localparam int ACC_W           = 44;
   localparam int QUO_W           = ACC_W - SPEED_FRAC_BITS;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 20;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SCALE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_PERIOD     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_ENCODER = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INVERT_OUTPUT  = 3'd7;

   typedef struct packed {
      logic signed [15:0] encoder_delta;
      logic signed [15:0] target_speed;
   } req_type;

   typedef struct packed {
      logic signed [16:0] duty;
      logic [15:0]        compare_a;
      logic [15:0]        compare_b;
      logic               low_a_on;
      logic               low_b_on;
      logic               restart_counters;
      logic signed [15:0] measured_speed;
   } rsp_type;

   typedef struct packed {
      logic [19:0] gain_p;
      logic [19:0] gain_i;
      logic [19:0] gain_d;
      logic [19:0] integral_limit;
      logic [15:0] speed_scale;
      logic [15:0] pwm_period;
      logic        invert_encoder;
      logic        invert_output;
   } cfg_type;

   // item after direction fixup, as queued between front and back
   typedef struct packed {
      logic signed [16:0] delta;
      logic signed [15:0] target;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } head_type;

   typedef struct packed {
      logic take;
   } take_type;

endpackage

`default_nettype wire

### design/pwsh_csr.sv
// ----------------------------------------------------------------------------
// pwsh_csr
// Configuration register file, always ready
// ----------------------------------------------------------------------------
`default_nettype none

module pwsh_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pwsh_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pwsh_pkg::CSR_DATA_W-1:0]     csr_data,
   output pwsh_pkg::cfg_type                        cfg
);

   pwsh_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pwsh_pkg::REG_GAIN_P:         cfg_in.gain_p         = csr_data;
            pwsh_pkg::REG_GAIN_I:         cfg_in.gain_i         = csr_data;
            pwsh_pkg::REG_GAIN_D:         cfg_in.gain_d         = csr_data;
            pwsh_pkg::REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_data;
            pwsh_pkg::REG_SPEED_SCALE:    cfg_in.speed_scale    = csr_data[15:0];
            pwsh_pkg::REG_PWM_PERIOD:     cfg_in.pwm_period     = csr_data[15:0];
            pwsh_pkg::REG_INVERT_ENCODER: cfg_in.invert_encoder = csr_data[0];
            pwsh_pkg::REG_INVERT_OUTPUT:  cfg_in.invert_output  = csr_data[0];
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p         <= 20'd65536;
         cfg_ff.gain_i         <= 20'd9830;
         cfg_ff.gain_d         <= 20'd65536;
         cfg_ff.integral_limit <= 20'd65536;
         cfg_ff.speed_scale    <= 16'd4096;
         cfg_ff.pwm_period     <= 16'd65535;
         cfg_ff.invert_encoder <= 1'b1;
         cfg_ff.invert_output  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### design/pwsh_front.sv
// ----------------------------------------------------------------------------
// pwsh_front
// Input side: accepts ticks, applies encoder direction, two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module pwsh_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   output logic                    req_full,
   input  wire pwsh_pkg::req_type  req_data,
   input  wire pwsh_pkg::cfg_type  cfg,
   output pwsh_pkg::head_type      head,
   input  wire pwsh_pkg::take_type take
);

   pwsh_pkg::item_type q_ff [2];
   pwsh_pkg::item_type entry;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       consume;
   logic signed [16:0] delta_ext;

   assign req_full = (count_ff == 2'd2);
   assign accept   = req_push && !req_full;
   assign consume  = take.take && (count_ff != 2'd0);

   assign delta_ext    = {req_data.encoder_delta[15], req_data.encoder_delta};
   assign entry.delta  = cfg.invert_encoder ? -delta_ext : delta_ext;
   assign entry.target = req_data.target_speed;

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = consume ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, consume};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

### design/pwsh_back.sv
// ----------------------------------------------------------------------------
// pwsh_back
// Control law sequencer on one shared multiplier, bridge drive, result queue
// ----------------------------------------------------------------------------
`default_nettype none

module pwsh_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pwsh_pkg::cfg_type  cfg,
   input  wire pwsh_pkg::head_type head,
   output pwsh_pkg::take_type      take,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output pwsh_pkg::rsp_type       rsp_data
);

   localparam int MW = pwsh_pkg::MUL_W;
   localparam int PW = pwsh_pkg::PROD_W;
   localparam int AW = pwsh_pkg::ACC_W;
   localparam int QW = pwsh_pkg::QUO_W;
   localparam int FB = pwsh_pkg::SPEED_FRAC_BITS;

   localparam logic signed [PW-1:0] MEAS_HI  = PW'(32767);
   localparam logic signed [PW-1:0] MEAS_LO  = -PW'(32768);
   localparam logic signed [AW-1:0] DIV_BIAS = AW'((1 << FB) - 1);
   localparam logic signed [QW-1:0] DUTY_HI  = QW'(pwsh_pkg::DUTY_MAX);
   localparam logic signed [QW-1:0] DUTY_LO  = -QW'(pwsh_pkg::DUTY_MAX);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCALE, ST_MEAS, ST_ERR, ST_INTEG, ST_MUL_P, ST_MUL_I,
      ST_MUL_D, ST_ACC, ST_DIV, ST_SAT, ST_DRIVE
   } state_type;

   state_type state_ff, state_in;

   // model state
   logic signed [21:0] integral_ff, integral_in;
   logic signed [15:0] prev_speed_ff, prev_speed_in;
   logic signed [16:0] prev_duty_ff, prev_duty_in;

   // result queue control
   logic       rq_wr_ff, rq_wr_in;
   logic       rq_rd_ff, rq_rd_in;
   logic [1:0] rq_count_ff, rq_count_in;
   pwsh_pkg::rsp_type rq_ff [2];
   pwsh_pkg::rsp_type result;
   logic       rq_push;
   logic       rq_pop;

   // datapath
   pwsh_pkg::item_type item_ff;
   logic signed [MW-1:0] op_a, op_b;
   logic signed [PW-1:0] mul_in, mul_ff;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [15:0]   meas_ff, meas_in;
   logic signed [16:0]   err_ff, deriv_ff;
   logic signed [16:0]   err_in, deriv_in;
   logic signed [QW-1:0] quo_ff, quo_in;
   logic signed [16:0]   duty_ff, duty_in;
   logic signed [PW-1:0] meas_shift;
   logic signed [22:0]   integ_sum;
   logic signed [22:0]   lim_pos;
   logic signed [AW-1:0] acc_biased;
   logic signed [AW-1:0] acc_shift;
   logic signed [QW-1:0] quo_dir;
   logic signed [17:0]   diff_a, diff_b;
   logic                 start;

   assign start     = (state_ff == ST_IDLE) && head.valid && (rq_count_ff != 2'd2);
   assign take.take = start;

   // shared multiplier operands
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         ST_SCALE: begin
            op_a = {{(MW-17){item_ff.delta[16]}}, item_ff.delta};
            op_b = {{(MW-16){1'b0}}, cfg.speed_scale};
         end
         ST_MUL_P: begin
            op_a = {1'b0, cfg.gain_p};
            op_b = {{(MW-17){err_ff[16]}}, err_ff};
         end
         ST_MUL_I: begin
            op_a = {1'b0, cfg.gain_i};
            op_b = integral_ff[MW-1:0];
         end
         ST_MUL_D: begin
            op_a = {1'b0, cfg.gain_d};
            op_b = {{(MW-17){deriv_ff[16]}}, deriv_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign mul_in = op_a * op_b;

   // floor of product over 65536, saturated to 16 bit
   assign meas_shift = mul_ff >>> 16;
   always_comb begin
      if (meas_shift > MEAS_HI) begin
         meas_in = 16'sd32767;
      end else if (meas_shift < MEAS_LO) begin
         meas_in = -16'sd32768;
      end else begin
         meas_in = meas_shift[15:0];
      end
   end

   assign err_in   = {item_ff.target[15], item_ff.target} - {meas_ff[15], meas_ff};
   assign deriv_in = {prev_speed_ff[15], prev_speed_ff} - {meas_ff[15], meas_ff};

   assign integ_sum = {integral_ff[21], integral_ff} + {{6{err_ff[16]}}, err_ff};
   assign lim_pos   = {3'b000, cfg.integral_limit};

   // divide truncating toward zero
   assign acc_biased = acc_ff + (acc_ff[AW-1] ? DIV_BIAS : '0);
   assign acc_shift  = acc_biased >>> FB;
   assign quo_in     = acc_shift[QW-1:0];
   assign quo_dir    = cfg.invert_output ? -quo_ff : quo_ff;

   always_comb begin
      if (quo_dir > DUTY_HI) begin
         duty_in = 17'sd65535;
      end else if (quo_dir < DUTY_LO) begin
         duty_in = -17'sd65535;
      end else begin
         duty_in = quo_dir[16:0];
      end
   end

   // bridge drive
   assign diff_a = {2'b00, cfg.pwm_period} - {duty_ff[16], duty_ff};
   assign diff_b = {2'b00, cfg.pwm_period} + {duty_ff[16], duty_ff};

   always_comb begin
      result.duty           = duty_ff;
      result.measured_speed = meas_ff;
      result.restart_counters = (prev_duty_ff == '0) || (duty_ff == '0)
                                || (prev_duty_ff[16] != duty_ff[16]);
      if (!duty_ff[16] && (duty_ff != '0)) begin
         result.low_a_on  = 1'b0;
         result.low_b_on  = 1'b1;
         result.compare_b = cfg.pwm_period;
         result.compare_a = diff_a[17] ? 16'd0 : diff_a[15:0];
      end else if (duty_ff[16]) begin
         result.low_a_on  = 1'b1;
         result.low_b_on  = 1'b0;
         result.compare_a = cfg.pwm_period;
         result.compare_b = diff_b[17] ? 16'd0 : diff_b[15:0];
      end else begin
         result.low_a_on  = 1'b1;
         result.low_b_on  = 1'b1;
         result.compare_a = cfg.pwm_period;
         result.compare_b = cfg.pwm_period;
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      integral_in   = integral_ff;
      prev_speed_in = prev_speed_ff;
      prev_duty_in  = prev_duty_ff;
      acc_in        = acc_ff;
      rq_push       = 1'b0;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MEAS;
         ST_MEAS:  state_in = ST_ERR;
         ST_ERR: begin
            prev_speed_in = meas_ff;
            state_in      = ST_INTEG;
         end
         ST_INTEG: begin
            if (integ_sum > lim_pos) begin
               integral_in = lim_pos[21:0];
            end else if (integ_sum < -lim_pos) begin
               integral_in = -lim_pos[21:0];
            end else begin
               integral_in = integ_sum[21:0];
            end
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            acc_in   = '0;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            acc_in   = acc_ff + {{(AW-PW){mul_ff[PW-1]}}, mul_ff};
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = acc_ff + {{(AW-PW){mul_ff[PW-1]}}, mul_ff};
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + {{(AW-PW){mul_ff[PW-1]}}, mul_ff};
            state_in = ST_DIV;
         end
         ST_DIV:   state_in = ST_SAT;
         ST_SAT:   state_in = ST_DRIVE;
         ST_DRIVE: begin
            rq_push      = 1'b1;
            prev_duty_in = duty_ff;
            state_in     = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign rq_pop    = rsp_pop && (rq_count_ff != 2'd0);
   assign rsp_empty = (rq_count_ff == 2'd0);
   assign rsp_data  = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in    = rq_push ? ~rq_wr_ff : rq_wr_ff;
      rq_rd_in    = rq_pop  ? ~rq_rd_ff : rq_rd_ff;
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         integral_ff   <= '0;
         prev_speed_ff <= '0;
         prev_duty_ff  <= '0;
         rq_wr_ff      <= 1'b0;
         rq_rd_ff      <= 1'b0;
         rq_count_ff   <= 2'd0;
      end else begin
         state_ff      <= state_in;
         integral_ff   <= integral_in;
         prev_speed_ff <= prev_speed_in;
         prev_duty_ff  <= prev_duty_in;
         rq_wr_ff      <= rq_wr_in;
         rq_rd_ff      <= rq_rd_in;
         rq_count_ff   <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) item_ff <= head.item;
      mul_ff <= mul_in;
      acc_ff <= acc_in;
      if (state_ff == ST_MEAS) meas_ff <= meas_in;
      if (state_ff == ST_ERR) begin
         err_ff   <= err_in;
         deriv_ff <= deriv_in;
      end
      if (state_ff == ST_DIV) quo_ff  <= quo_in;
      if (state_ff == ST_SAT) duty_ff <= duty_in;
      if (rq_push) rq_ff[rq_wr_ff] <= result;
   end

endmodule

`default_nettype wire

### design/pid_wheel_speed_hbridge.sv
// ----------------------------------------------------------------------------
// pid_wheel_speed_hbridge
// Wheel speed PID with integral clamp, derivative on measurement, H-bridge drive
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_push, req_full, req_data            push & !full
//  response  rsp_empty, rsp_pop, rsp_data            pop & !empty
//  config    csr_valid, csr_ready, csr_index/data    valid & ready
//
//  the sequencer takes a new item only in idle and runs the speed
//  scaling and the three gain products through one shared 21x21 multiplier
//  a result enters the result queue in the last sequencer state; a two-entry
//  queue on each side lets input and output stall independently, and a full
//  result queue holds the sequencer in idle
//  reset is synchronous and clears controller state and both queues
// ----------------------------------------------------------------------------
`default_nettype none

module pid_wheel_speed_hbridge (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire pwsh_pkg::req_type               req_data,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output pwsh_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [pwsh_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pwsh_pkg::CSR_DATA_W-1:0] csr_data
);

   pwsh_pkg::cfg_type  cfg;
   pwsh_pkg::head_type head;
   pwsh_pkg::take_type take;

   pwsh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwsh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg),
      .head     (head),
      .take     (take)
   );

   pwsh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .take      (take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### design/pwsh_checker.sv
// ----------------------------------------------------------------------------
// pwsh_checker
// Port-level checks of the wheel speed controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pwsh_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_push,
   input wire logic                            req_full,
   input wire pwsh_pkg::req_type               req_data,
   input wire logic                            rsp_empty,
   input wire logic                            rsp_pop,
   input wire pwsh_pkg::rsp_type               rsp_data,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready,
   input wire logic [pwsh_pkg::CSR_IDX_W-1:0]  csr_index,
   input wire logic [pwsh_pkg::CSR_DATA_W-1:0] csr_data
);

   // no result can be waiting right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   // a waiting item holds until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed");

   // forward drive: only low side b on
   a_forward: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.duty[16] && (rsp_data.duty != '0))
      |-> (!rsp_data.low_a_on && rsp_data.low_b_on && !rsp_data.restart_counters
           || !rsp_data.low_a_on && rsp_data.low_b_on && rsp_data.restart_counters))
      else $error("forward drive pins wrong");

   // reverse drive: only low side a on
   a_reverse: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.duty[16]) |-> (rsp_data.low_a_on && !rsp_data.low_b_on))
      else $error("reverse drive pins wrong");

   // zero duty brakes and always restarts the counters
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.duty == '0))
      |-> (rsp_data.low_a_on && rsp_data.low_b_on && rsp_data.restart_counters
           && (rsp_data.compare_a == rsp_data.compare_b)))
      else $error("zero duty drive wrong");

endmodule

bind pid_wheel_speed_hbridge pwsh_checker u_checker (.*);

`default_nettype wire
